// ----- sv/leb_pkg.sv -----
package leb_pkg;

   localparam int unsigned AccWidth  = 64;
   localparam int unsigned CntWidth  = 4;
   localparam int unsigned DigitBits = 7;
   // index of the tenth byte, the last one that can land in 64 bits
   localparam logic [CntWidth-1:0] LastByteIdx = 4'd9;

   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_REDUNDANT = 2'd1,
      STATUS_OVERFLOW  = 2'd2,
      STATUS_TRUNCATED = 2'd3
   } status_type;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
      logic       is_signed;
   } req_type;

   typedef struct packed {
      logic [AccWidth-1:0] value_bits;
      status_type          status;
   } rsp_type;

   typedef struct packed {
      logic [AccWidth-1:0] acc;
      logic [CntWidth-1:0] cnt;
      logic                prior_sign;
      logic                signed_latched;
   } state_type;

endpackage

// ----- sv/leb128_stream_decoder_top.sv -----
// LEB128 decoder, one byte per request, 64-bit unsigned or signed result.
// A result appears on rsp in the cycle after the request holding its last byte is accepted.
// Throughput: one request per cycle; set by the combinational decode of one byte
// into the value accumulator. A waiting result stalls req only while rsp_ready is low.
// Reset (synchronous, active high) clears the accumulator, byte count and rsp_valid.
module leb128_stream_decoder_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  leb_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output leb_pkg::rsp_type rsp_payload
);
   import leb_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   logic      emit;
   logic      accept;

   leb_step u_step (
      .state_cur (state_ff),
      .req       (req_payload),
      .state_nxt (state_in),
      .emit      (emit),
      .rsp       (rsp_data_in)
   );

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         // a new result replaces one that leaves in the same cycle
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_data_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- sv/leb_step.sv -----
module leb_step (
   input  leb_pkg::state_type state_cur,
   input  leb_pkg::req_type   req,
   output leb_pkg::state_type state_nxt,
   output logic               emit,
   output leb_pkg::rsp_type   rsp
);
   import leb_pkg::*;

   logic [6:0]          payload;
   logic                more;
   logic                sgn;
   logic                last;
   logic                redundant;
   logic [6:0]          shift_amt;
   logic [6:0]          ext_amt;
   logic [AccWidth-1:0] acc_or;
   logic [AccWidth-1:0] ext_mask;

   assign payload   = req.data_byte[6:0];
   assign more      = req.data_byte[7];
   assign sgn       = (state_cur.cnt == '0) ? req.is_signed : state_cur.signed_latched;
   assign last      = (state_cur.cnt == LastByteIdx);
   assign shift_amt = 7'(7'(state_cur.cnt) * 7'(DigitBits));
   assign ext_amt   = 7'(shift_amt + 7'(DigitBits));
   assign acc_or    = state_cur.acc | (AccWidth'(payload) << shift_amt);

   // padding byte: all zero (after a clear sign bit when signed), or all ones after a set sign bit (signed only)
   assign redundant = (state_cur.cnt != '0) &&
                      (sgn ? ((payload == 7'h7f &&  state_cur.prior_sign) ||
                              (payload == 7'h00 && !state_cur.prior_sign))
                           : (payload == 7'h00));

   // sign fill above the last digit; tenth byte gets none
   assign ext_mask = (sgn && req.data_byte[6] && (state_cur.cnt < LastByteIdx))
                     ? ({AccWidth{1'b1}} << ext_amt) : '0;

   always_comb begin
      state_nxt      = '0;
      emit           = 1'b0;
      rsp.value_bits = '0;
      rsp.status     = STATUS_OK;
      priority if (req.op == OP_END) begin
         if (state_cur.cnt != '0) begin
            emit       = 1'b1;
            rsp.status = STATUS_TRUNCATED;
         end
      end else if (state_cur.cnt > LastByteIdx) begin
         emit       = 1'b1;
         rsp.status = STATUS_OVERFLOW;
      end else if (!sgn && last && req.data_byte != 8'h01) begin
         emit       = 1'b1;
         rsp.status = STATUS_OVERFLOW;
      end else if (!more) begin
         emit           = 1'b1;
         rsp.value_bits = acc_or | ext_mask;
         rsp.status     = redundant ? STATUS_REDUNDANT : STATUS_OK;
      end else if (last) begin
         emit       = 1'b1;
         rsp.status = STATUS_OVERFLOW;
      end else begin
         state_nxt.acc            = acc_or;
         state_nxt.cnt            = CntWidth'(state_cur.cnt + 1'b1);
         state_nxt.prior_sign     = req.data_byte[6];
         state_nxt.signed_latched = sgn;
      end
   end

endmodule
